FILE: rtl/core/sorted_priority_queue_with_rekey_core_defines.svh
// Assertion macros for the sorted priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_WITH_REKEY_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_WITH_REKEY_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue core.
`default_nettype none
package spq_pkg;
    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_BITS = 32;
    localparam int PRIO_W   = 16;
    localparam int CMD_W    = 2;
    localparam int STS_W    = 3;
    localparam int OP_W     = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_EMPTY     = 3'd1;
    localparam logic [STS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd3;
    localparam logic [STS_W-1:0] STS_UNCHANGED = 3'd4;

    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_MATCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_PICK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_POP    = 3'd5;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_BITS-1:0] key;
        logic [PRIO_W-1:0]   pv;
        logic [CNT_W-1:0]    count;
        logic                any_pend;
        logic                prio_kept;
        logic                pick_same;
        logic                pick_last;
        logic [KEY_BITS-1:0] sel_key;
        logic [PRIO_W-1:0]   sel_prio;
        logic [CNT_W-1:0]    sel_pos;
        logic [CNT_W-1:0]    moved;
    } t_dp_stat;

    typedef struct packed {
        logic [STS_W-1:0]    status;
        logic [KEY_BITS-1:0] key;
        logic [PRIO_W-1:0]   prio;
        logic [CNT_W-1:0]    pos;
        logic [CNT_W-1:0]    moved;
        logic                last;
    } t_out_beat;
endpackage
`default_nettype wire

FILE: rtl/core/spq_ifs.sv
// Input and result channel interfaces of the sorted priority queue core.
`default_nettype none
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] name_key;
    logic signed [15:0] priority_value;
    modport source (output valid, output command, output name_key,
                    output priority_value, input ready);
    modport sink (input valid, input command, input name_key,
                  input priority_value, output ready);
endinterface

interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] entry_key;
    logic signed [15:0] entry_priority;
    logic [4:0]  entry_position;
    logic [4:0]  moved_count;
    logic        last_result;
    modport source (output valid, output status, output entry_key, output entry_priority,
                    output entry_position, output moved_count, output last_result,
                    input ready);
    modport sink (input valid, input status, input entry_key, input entry_priority,
                  input entry_position, input moved_count, input last_result,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spq_datapath.sv
// Entry store, match flags and shift logic of the sorted priority queue.
`default_nettype none
module spq_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire spq_pkg::t_dp_cmd               i_cmd,
    input  wire logic [spq_pkg::CMD_W-1:0]      i_command,
    input  wire logic [spq_pkg::KEY_BITS-1:0]   i_name_key,
    input  wire logic [spq_pkg::PRIO_W-1:0]     i_priority_value,
    output spq_pkg::t_dp_stat                   o_stat
);
    import spq_pkg::*;

    function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (v[k]) idx = IDX_W'(k);
        end
        return idx;
    endfunction

    logic [KEY_BITS-1:0] r_keys  [DEPTH];
    logic [PRIO_W-1:0]   r_prios [DEPTH];
    logic [KEY_BITS-1:0] n_keys  [DEPTH];
    logic [PRIO_W-1:0]   n_prios [DEPTH];
    logic [DEPTH-1:0]    r_pend, n_pend;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_moved, n_moved;
    logic [IDX_W-1:0]    r_at, n_at;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [PRIO_W-1:0]   r_pv, n_pv;
    logic                r_prio_kept, n_prio_kept;

    logic [DEPTH-1:0] valid_v, match_v, diff_v, ge_v, pend_clr;
    logic [IDX_W-1:0] first, sel_idx, slot, rm_idx;
    logic             any_pend;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_v[i] = CNT_W'(i) < r_count;
            match_v[i] = valid_v[i] && (r_keys[i] == r_key);
            diff_v[i]  = match_v[i] && (r_prios[i] != r_pv);
            ge_v[i]    = valid_v[i] && ($signed(r_prios[i]) >= $signed(r_pv));
        end
        any_pend = |r_pend;
        first    = first_set(r_pend);
        sel_idx  = any_pend ? first : '0;
        pend_clr = r_pend & ~(DEPTH'(1) << first);
        slot     = first_set(~ge_v);
        rm_idx   = (i_cmd.op == OP_POP) ? '0 : r_at;
    end

    always_comb begin
        n_keys      = r_keys;
        n_prios     = r_prios;
        n_pend      = r_pend;
        n_count     = r_count;
        n_moved     = r_moved;
        n_at        = r_at;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pv        = r_pv;
        n_prio_kept = r_prio_kept;
        unique case (i_cmd.op) inside
            OP_LOAD: begin
                n_cmd   = i_command;
                n_key   = i_name_key;
                n_pv    = i_priority_value;
                n_pend  = '0;
                n_moved = '0;
            end
            OP_MATCH: begin
                n_pend      = match_v;
                n_prio_kept = ~|diff_v;
            end
            OP_PICK: begin
                n_pend = pend_clr;
                n_at   = first;
            end
            OP_REMOVE, OP_POP: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (IDX_W'(i) >= rm_idx) begin
                        n_keys[i]  = r_keys[i+1];
                        n_prios[i] = r_prios[i+1];
                        n_pend[i]  = r_pend[i+1];
                    end
                end
                n_pend[DEPTH-1] = 1'b0;
                n_count = r_count - 1'b1;
                if (i_cmd.op == OP_REMOVE) n_moved = r_moved + 1'b1;
            end
            OP_INSERT: begin
                for (int i = 1; i < DEPTH; i++) begin
                    if (IDX_W'(i) > slot) begin
                        n_keys[i]  = r_keys[i-1];
                        n_prios[i] = r_prios[i-1];
                        n_pend[i]  = r_pend[i-1];
                    end
                end
                n_keys[slot]  = r_key;
                n_prios[slot] = r_pv;
                n_pend[slot]  = 1'b0;
                n_count = r_count + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_keys      <= n_keys;
        r_prios     <= n_prios;
        r_at        <= n_at;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_pv        <= n_pv;
        r_prio_kept <= n_prio_kept;
        r_moved     <= n_moved;
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= '0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.key       = r_key;
        o_stat.pv        = r_pv;
        o_stat.count     = r_count;
        o_stat.any_pend  = any_pend;
        o_stat.prio_kept = r_prio_kept;
        o_stat.pick_same = r_prios[first] == r_pv;
        o_stat.pick_last = ~|pend_clr;
        o_stat.sel_key   = r_keys[sel_idx];
        o_stat.sel_prio  = r_prios[sel_idx];
        o_stat.sel_pos   = CNT_W'(sel_idx) + 1'b1;
        o_stat.moved     = r_moved;
    end
endmodule
`default_nettype wire

FILE: rtl/core/spq_controller.sv
// Command sequencer and result register of the sorted priority queue.
`default_nettype none
module spq_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output spq_pkg::t_out_beat      o_beat,
    input  wire spq_pkg::t_dp_stat  i_stat,
    output spq_pkg::t_dp_cmd        o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;
    localparam logic [2:0] S_FIND   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    t_out_beat  r_beat, n_beat;
    logic       emit;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_beat   = r_beat;
        o_cmd.op = OP_NONE;
        emit     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.cmd == CMD_ADD) begin
                    if (i_stat.count == CNT_W'(DEPTH)) begin
                        emit   = 1'b1;
                        n_beat = '{STS_FULL, i_stat.key, '0, '0, '0, 1'b1};
                    end else begin
                        n_state = S_INSERT;
                    end
                end else if (i_stat.count == '0) begin
                    emit   = 1'b1;
                    n_beat = '{STS_EMPTY, '0, '0, '0, '0, 1'b1};
                end else if (i_stat.cmd == CMD_REMOVE) begin
                    o_cmd.op = OP_POP;
                    emit     = 1'b1;
                    n_beat   = '{STS_OK, i_stat.sel_key, i_stat.sel_prio, '0, '0, 1'b1};
                end else begin
                    o_cmd.op = OP_MATCH;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.any_pend) begin
                    emit   = 1'b1;
                    n_beat = '{STS_NOT_FOUND, i_stat.key, '0, '0, '0, 1'b1};
                end else if (i_stat.cmd == CMD_FIND) begin
                    n_state = S_FIND;
                end else if (i_stat.prio_kept) begin
                    emit   = 1'b1;
                    n_beat = '{STS_UNCHANGED, i_stat.key, '0, '0, '0, 1'b1};
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_stat.any_pend) begin
                    emit   = 1'b1;
                    n_beat = '{STS_OK, i_stat.key, i_stat.pv, '0, i_stat.moved, 1'b1};
                end else begin
                    o_cmd.op = OP_PICK;
                    n_state  = i_stat.pick_same ? S_PICK : S_REMOVE;
                end
            end
            S_REMOVE: begin
                o_cmd.op = OP_REMOVE;
                n_state  = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.op = OP_INSERT;
                if (i_stat.cmd == CMD_ADD) begin
                    emit   = 1'b1;
                    n_beat = '{STS_OK, i_stat.key, i_stat.pv, '0, '0, 1'b1};
                end else begin
                    n_state = S_PICK;
                end
            end
            S_FIND: begin
                o_cmd.op = OP_PICK;
                emit     = 1'b1;
                n_beat   = '{STS_OK, i_stat.sel_key, i_stat.sel_prio, i_stat.sel_pos, '0,
                             i_stat.pick_last};
            end
            S_OUT: begin
                if (i_out_ready) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
        if (emit) begin
            n_state = S_OUT;
            n_ret   = (r_state == S_FIND && !i_stat.pick_last) ? S_FIND : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_beat      = r_beat;
endmodule
`default_nettype wire

FILE: rtl/core/sorted_priority_queue_with_rekey_core.sv
// Top level of the sorted priority queue with rekey.
// Holds up to 16 entries (32-bit key, signed 16-bit priority) in descending
// priority order, ties in arrival order, all in flip-flops. One item is in
// work at a time. Add checks for room and inserts; remove pops the head;
// find marks the matches and gives one result beat per match; change marks
// the matches and removes and reinserts each one whose priority differs.
// Empty, full, not found and unchanged give a single status beat. Input
// ready returns only once the last beat is taken, so the results of an
// item are delivered before the next item is taken.
`default_nettype none
`include "sorted_priority_queue_with_rekey_core_defines.svh"
module sorted_priority_queue_with_rekey_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;
    t_out_beat beat;

    spq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_command        (i_in.command),
        .i_name_key       (i_in.name_key),
        .i_priority_value (i_in.priority_value),
        .o_stat           (dp_stat)
    );

    spq_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_beat      (beat),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    assign o_out.status         = beat.status;
    assign o_out.entry_key      = beat.key;
    assign o_out.entry_priority = beat.prio;
    assign o_out.entry_position = beat.pos;
    assign o_out.moved_count    = beat.moved;
    assign o_out.last_result    = beat.last;

    `SPQ_ASSERT_NOW(a_ready_no_result, i_in.ready, !o_out.valid, "input taken while beat pending")
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, dp_stat.count <= CNT_W'(DEPTH), "entry count overflow")
    `SPQ_ASSERT_NEXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready, "second item accepted")
endmodule
`default_nettype wire

FILE: sim/spq_tb_ifs.sv
// Interfaces are defined in the RTL; this file holds the stimulus row and result types.
`default_nettype none
package spq_tb_pkg;
    import spq_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [31:0]         key;
        logic signed [15:0]  prio;
        bit                  has_exp;
        logic [STS_W-1:0]    exp_status;
        logic [31:0]         exp_key;
        logic signed [15:0]  exp_prio;
    } t_cmd_row;

    typedef struct {
        logic [STS_W-1:0]    status;
        logic [31:0]         key;
        logic signed [15:0]  prio;
        logic [4:0]          pos;
        logic [4:0]          moved;
        logic                last;
    } t_result;
endpackage
`default_nettype wire

FILE: sim/sorted_priority_queue_with_rekey_core_tb.sv
// Self-checking testbench of the sorted priority queue core: directed table, then random commands.
`default_nettype none
module sorted_priority_queue_with_rekey_core_tb;
    import spq_pkg::*;
    import spq_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_with_rekey_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [31:0]        q_keys[$];
    logic signed [15:0] q_prios[$];
    t_result            pending_results[$];
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int slot_for(logic signed [15:0] p);
        int i;
        i = 0;
        while (i < q_keys.size() && q_prios[i] >= p) i++;
        return i;
    endfunction

    function automatic t_result mk(logic [2:0] st, logic [31:0] k, logic signed [15:0] p,
                                   logic [4:0] pos, logic [4:0] mv, logic last);
        t_result r;
        r.status = st; r.key = k; r.prio = p; r.pos = pos; r.moved = mv; r.last = last;
        return r;
    endfunction

    task automatic predict_queue(logic [1:0] cmd, logic [31:0] key, logic signed [15:0] pv);
        int i, at, match_cnt, seen, moved;
        bit prio_kept;
        bit pend[$];
        logic [31:0] k;
        match_cnt = 0; seen = 0; moved = 0; prio_kept = 1;
        if (cmd == CMD_ADD) begin
            if (q_keys.size() >= DEPTH) begin
                pending_results.push_back(mk(STS_FULL, key, 0, 0, 0, 1));
            end else begin
                at = slot_for(pv);
                q_keys.insert(at, key);
                q_prios.insert(at, pv);
                pending_results.push_back(mk(STS_OK, key, pv, 0, 0, 1));
            end
            return;
        end
        if (q_keys.size() == 0) begin
            pending_results.push_back(mk(STS_EMPTY, 0, 0, 0, 0, 1));
            return;
        end
        if (cmd == CMD_REMOVE) begin
            pending_results.push_back(mk(STS_OK, q_keys[0], q_prios[0], 0, 0, 1));
            void'(q_keys.pop_front());
            void'(q_prios.pop_front());
            return;
        end
        for (i = 0; i < q_keys.size(); i++) begin
            pend.push_back(q_keys[i] == key);
            if (q_keys[i] == key) begin
                match_cnt++;
                if (q_prios[i] != pv) prio_kept = 0;
            end
        end
        if (match_cnt == 0) begin
            pending_results.push_back(mk(STS_NOT_FOUND, key, 0, 0, 0, 1));
            return;
        end
        if (cmd == CMD_FIND) begin
            for (i = 0; i < q_keys.size(); i++) begin
                if (pend[i]) begin
                    seen++;
                    pending_results.push_back(mk(STS_OK, q_keys[i], q_prios[i], 5'(i + 1), 0,
                                                 seen == match_cnt));
                end
            end
            return;
        end
        if (prio_kept) begin
            pending_results.push_back(mk(STS_UNCHANGED, key, 0, 0, 0, 1));
            return;
        end
        forever begin
            at = -1;
            for (i = 0; i < q_keys.size(); i++) begin
                if (pend[i]) begin
                    at = i;
                    break;
                end
            end
            if (at < 0) break;
            pend[at] = 0;
            if (q_prios[at] == pv) continue;
            k = q_keys[at];
            q_keys.delete(at); q_prios.delete(at); pend.delete(at);
            i = slot_for(pv);
            q_keys.insert(i, k); q_prios.insert(i, pv); pend.insert(i, 0);
            moved++;
        end
        pending_results.push_back(mk(STS_OK, key, pv, 0, 5'(moved), 1));
    endtask

    task automatic send_beat(t_cmd_row row);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.command        <= row.cmd;
        in_ch.name_key       <= row.key;
        in_ch.priority_value <= row.prio;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_queue(row.cmd, row.key, row.prio);
        if (row.has_exp && (pending_results[$].status != row.exp_status ||
                            pending_results[$].key != row.exp_key ||
                            pending_results[$].prio != row.exp_prio)) begin
            $display("%0t table row mismatch: expected st %0d key %h prio %0d, model st %0d",
                     $time, row.exp_status, row.exp_key, row.exp_prio,
                     pending_results[$].status);
            fail_count++;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected beat: st %0d key %h", $time, out_ch.status,
                         out_ch.entry_key);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (out_ch.status !== e.status || out_ch.entry_key !== e.key ||
                    out_ch.entry_priority !== e.prio || out_ch.entry_position !== e.pos ||
                    out_ch.moved_count !== e.moved || out_ch.last_result !== e.last) begin
                    $display("%0t mismatch: expected st %0d key %h prio %0d pos %0d mv %0d last %0d",
                             $time, e.status, e.key, e.prio, e.pos, e.moved, e.last);
                    $display("%0t           actual st %0d key %h prio %0d pos %0d mv %0d last %0d",
                             $time, out_ch.status, out_ch.entry_key, out_ch.entry_priority,
                             out_ch.entry_position, out_ch.moved_count, out_ch.last_result);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_cmd_row row_of(logic [1:0] c, logic [31:0] k, logic signed [15:0] p);
        t_cmd_row r;
        r.cmd = c; r.key = k; r.prio = p; r.has_exp = 0;
        r.exp_status = STS_OK; r.exp_key = 0; r.exp_prio = 0;
        return r;
    endfunction

    function automatic t_cmd_row row_exp(logic [1:0] c, logic [31:0] k, logic signed [15:0] p,
                                         logic [2:0] st, logic [31:0] ek,
                                         logic signed [15:0] ep);
        t_cmd_row r;
        r = row_of(c, k, p);
        r.has_exp = 1; r.exp_status = st; r.exp_key = ek; r.exp_prio = ep;
        return r;
    endfunction

    function automatic t_cmd_row rand_row(int n_keys);
        logic [1:0] c;
        logic [31:0] k;
        logic signed [15:0] p;
        int sel;
        sel = $urandom_range(99);
        c = sel < 40 ? CMD_ADD : sel < 60 ? CMD_REMOVE : sel < 80 ? CMD_CHANGE : CMD_FIND;
        k = ($urandom_range(9) == 0) ? $urandom : $urandom_range(n_keys - 1) | 32'hA5A50000;
        if ($urandom_range(3) == 0) k = $urandom_range(n_keys - 1);
        p = ($urandom_range(4) == 0) ? $signed(16'($urandom))
                                     : $signed(16'($urandom_range(6))) - 16'sd3;
        return row_of(c, k, p);
    endfunction

    initial begin
        t_cmd_row directed[$];
        int ph, n;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_ADD;
        in_ch.name_key = 0;
        in_ch.priority_value = 0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed.push_back(row_exp(CMD_REMOVE, 32'h1, 0, STS_EMPTY, 0, 0));
        directed.push_back(row_exp(CMD_CHANGE, 32'h1, 5, STS_EMPTY, 0, 0));
        directed.push_back(row_exp(CMD_FIND, 32'h1, 0, STS_EMPTY, 0, 0));
        directed.push_back(row_exp(CMD_ADD, 32'hFFFF_FFFF, 16'sh7FFF, STS_OK,
                                   32'hFFFF_FFFF, 16'sh7FFF));
        directed.push_back(row_exp(CMD_ADD, 32'h0, -16'sd32768, STS_OK, 32'h0, -16'sd32768));
        directed.push_back(row_of(CMD_ADD, 32'h7, 3));
        directed.push_back(row_of(CMD_ADD, 32'h7, 3));
        directed.push_back(row_of(CMD_ADD, 32'h7, -1));
        directed.push_back(row_of(CMD_FIND, 32'h7, 0));
        directed.push_back(row_exp(CMD_FIND, 32'h55, 0, STS_NOT_FOUND, 32'h55, 0));
        directed.push_back(row_exp(CMD_CHANGE, 32'h56, 0, STS_NOT_FOUND, 32'h56, 0));
        directed.push_back(row_of(CMD_CHANGE, 32'h7, 9));
        directed.push_back(row_exp(CMD_CHANGE, 32'h7, 9, STS_UNCHANGED, 32'h7, 0));
        directed.push_back(row_of(CMD_CHANGE, 32'h0, 16'sh7FFF));
        directed.push_back(row_of(CMD_REMOVE, 0, 0));
        for (int i = 0; i < 12; i++) directed.push_back(row_of(CMD_ADD, 32'h7, i - 6));
        directed.push_back(row_exp(CMD_ADD, 32'h9, 0, STS_FULL, 32'h9, 0));
        directed.push_back(row_of(CMD_FIND, 32'h7, 0));
        directed.push_back(row_of(CMD_CHANGE, 32'h7, 0));
        foreach (directed[i]) send_beat(directed[i]);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) send_beat(row_of(CMD_REMOVE, 0, 0));

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 34 : 61) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 34 : 61) : 0;
            for (n = 0; n < 37; n++) begin
                if (n == 20) while (pending_results.size() != 0) @(negedge i_clk);
                send_beat(rand_row(ph == 0 ? 3 : 6));
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t %0d expected beats never arrived", $time, pending_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
